// ===== rtl/flow_log_hit_counter_table_unit_defines.svh =====
// assertion macros shared by the flow log table modules
`ifndef FLOW_LOG_HIT_COUNTER_TABLE_UNIT_DEFINES_SVH
`define FLOW_LOG_HIT_COUNTER_TABLE_UNIT_DEFINES_SVH

// checked outside reset
`define FLHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define FLHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/flht_pkg.sv =====
// types and constants of the flow log hit counter table
package flht_pkg;

  localparam int ENTRIES_W  = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RELATED_REASON = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_VERDICT = 1'b1;

  localparam logic signed [7:0] RELATED_REASON_RST = 8'sd0;
  localparam logic [7:0]        ACCEPT_VERDICT_RST = 8'd1;

  typedef enum logic [1:0] {
    OP_LOG   = 2'd0,
    OP_EST   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERT   = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_PAST_END = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [7:0]         protocol;
    logic [31:0]        src_ip;
    logic [31:0]        dst_ip;
    logic [15:0]        sport;
    logic [15:0]        dport;
    logic signed [7:0]  reason;
    logic [7:0]         verdict;
    logic [31:0]        now_seconds;
    logic [11:0]        read_index;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [7:0]             row_protocol;
    logic [7:0]             row_action;
    logic [31:0]            row_src_ip;
    logic [31:0]            row_dst_ip;
    logic [15:0]            row_sport;
    logic [15:0]            row_dport;
    logic signed [7:0]      row_reason;
    logic [31:0]            row_timestamp;
    logic [31:0]            row_count;
    logic [ENTRIES_W-1:0]   entries_used;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        protocol;
    logic [7:0]        action;
    logic [31:0]       src_ip;
    logic [31:0]       dst_ip;
    logic [15:0]       sport;
    logic [15:0]       dport;
    logic signed [7:0] reason;
    logic [31:0]       stamp;
    logic [31:0]       hits;
  } row_t;

  typedef struct packed {
    logic    load;
    logic    scan_step;
    logic    rd_index;
    logic    finish;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic full;
    logic idx_ok;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/flht_stream_if.sv =====
// valid/ready stream channel
interface flht_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/flht_ctrl.sv =====
// controller state machine of the flow log table
`include "flow_log_hit_counter_table_unit_defines.svh"

module flht_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  flht_pkg::op_e   in_op_i,
  output logic            in_ready_o,
  input  flht_pkg::stat_t stat_i,
  output flht_pkg::cmd_t  cmd_o
);
  import flht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT,
    S_MISS,
    S_RD_ISSUE,
    S_RD_OUT,
    S_CLEAR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_HIT;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_op_i)
            OP_LOG, OP_EST: state_d = S_SCAN;
            OP_CLEAR:       state_d = S_CLEAR;
            OP_READ:        state_d = S_RD_ISSUE;
            default:        state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          state_d = S_HIT;
        end else if (stat_i.scan_done) begin
          state_d = S_MISS;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_HIT: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_HIT;
          state_d      = S_IDLE;
        end
      end
      S_MISS: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = stat_i.full ? ST_FULL : ST_INSERT;
          state_d      = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        if (stat_i.idx_ok) begin
          cmd_o.rd_index = 1'b1;
          state_d        = S_RD_OUT;
        end else if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_PAST_END;
          state_d      = S_IDLE;
        end
      end
      S_RD_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_READ_OK;
          state_d      = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_CLEARED;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FLHT_ASSERT(a_load_leaves_idle, clk_i, rst_ni, cmd_o.load |=> (state_q != S_IDLE), "load did not start work")
  `FLHT_ASSERT(a_rd_out_after_issue, clk_i, rst_ni, (state_q == S_RD_OUT) |-> ($past(cmd_o.rd_index) || $past(state_q == S_RD_OUT)), "row read without issue")
  `FLHT_ASSERT(a_finish_to_idle, clk_i, rst_ni, cmd_o.finish |=> (state_q == S_IDLE), "finish did not return to idle")

endmodule

// ===== rtl/flht_dpath.sv =====
// datapath of the flow log table: row memory, scan compare, counters, result register
`include "flow_log_hit_counter_table_unit_defines.svh"

module flht_dpath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [flht_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [flht_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  flht_pkg::in_item_t                  in_item_i,
  input  flht_pkg::cmd_t                      cmd_i,
  output flht_pkg::stat_t                     stat_o,
  output logic                                out_valid_o,
  output flht_pkg::out_item_t                 out_item_o,
  input  logic                                out_ready_i
);
  import flht_pkg::*;

  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  row_t              mem_q [TABLE_DEPTH];
  row_t              rd_q;
  logic [IDXW-1:0]   rd_idx_q;
  logic              rd_vld_q;
  logic [CNTW-1:0]   scan_addr_q;
  logic [CNTW-1:0]   count_q, count_d;
  in_item_t          item_q;
  out_item_t         out_q, out_d;
  logic              out_vld_q;
  logic signed [7:0] related_reason_q;
  logic [7:0]        accept_verdict_q;

  logic              issue, rd_en, wr_en;
  logic [IDXW-1:0]   rd_addr, wr_addr;
  row_t              wr_row, upd_row, new_row;
  logic              fwd, rev;

  function automatic out_item_t row_out(row_t r, status_e s, logic [ENTRIES_W-1:0] n);
    out_item_t o;
    o.status        = s;
    o.row_protocol  = r.protocol;
    o.row_action    = r.action;
    o.row_src_ip    = r.src_ip;
    o.row_dst_ip    = r.dst_ip;
    o.row_sport     = r.sport;
    o.row_dport     = r.dport;
    o.row_reason    = r.reason;
    o.row_timestamp = r.stamp;
    o.row_count     = r.hits;
    o.entries_used  = n;
    return o;
  endfunction

  // tuple compare against the row read last cycle
  assign fwd = (rd_q.protocol == item_q.protocol) && (rd_q.src_ip == item_q.src_ip) &&
               (rd_q.dst_ip == item_q.dst_ip) && (rd_q.sport == item_q.sport) &&
               (rd_q.dport == item_q.dport);
  assign rev = (rd_q.protocol == item_q.protocol) && (rd_q.src_ip == item_q.dst_ip) &&
               (rd_q.dst_ip == item_q.src_ip) && (rd_q.sport == item_q.dport) &&
               (rd_q.dport == item_q.sport);

  always_comb begin
    stat_o.hit       = rd_vld_q && ((item_q.operation == OP_LOG) ?
                       ((rd_q.reason == item_q.reason) && fwd) : (fwd || rev));
    stat_o.scan_done = !rd_vld_q && !(scan_addr_q < count_q);
    stat_o.full      = (count_q == CNTW'(TABLE_DEPTH));
    stat_o.idx_ok    = ENTRIES_W'(item_q.read_index) < ENTRIES_W'(count_q);
    stat_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign issue   = cmd_i.scan_step && (scan_addr_q < count_q);
  assign rd_en   = issue || cmd_i.rd_index;
  assign rd_addr = cmd_i.rd_index ? item_q.read_index[IDXW-1:0] : scan_addr_q[IDXW-1:0];

  always_comb begin
    upd_row       = rd_q;
    upd_row.stamp = item_q.now_seconds;
    upd_row.hits  = (rd_q.hits == '1) ? rd_q.hits : rd_q.hits + 32'd1;

    new_row.protocol = item_q.protocol;
    new_row.src_ip   = item_q.src_ip;
    new_row.dst_ip   = item_q.dst_ip;
    new_row.sport    = item_q.sport;
    new_row.dport    = item_q.dport;
    new_row.stamp    = item_q.now_seconds;
    new_row.hits     = 32'd1;
    if (item_q.operation == OP_LOG) begin
      new_row.reason = item_q.reason;
      new_row.action = item_q.verdict;
    end else begin
      new_row.reason = related_reason_q;
      new_row.action = accept_verdict_q;
    end
  end

  always_comb begin
    wr_en   = cmd_i.finish && ((cmd_i.status == ST_HIT) || (cmd_i.status == ST_INSERT));
    wr_addr = (cmd_i.status == ST_HIT) ? rd_idx_q : count_q[IDXW-1:0];
    wr_row  = (cmd_i.status == ST_HIT) ? upd_row : new_row;
    count_d = count_q;
    if (cmd_i.finish && (cmd_i.status == ST_INSERT)) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.finish && (cmd_i.status == ST_CLEARED)) begin
      count_d = '0;
    end
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.status)
      ST_HIT:     out_d = row_out(upd_row, ST_HIT, ENTRIES_W'(count_d));
      ST_INSERT:  out_d = row_out(new_row, ST_INSERT, ENTRIES_W'(count_d));
      ST_READ_OK: out_d = row_out(rd_q, ST_READ_OK, ENTRIES_W'(count_d));
      default: begin
        out_d.status       = cmd_i.status;
        out_d.entries_used = ENTRIES_W'(count_d);
      end
    endcase
  end

  // row memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    if (issue) begin
      rd_idx_q <= scan_addr_q[IDXW-1:0];
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q          <= '0;
      scan_addr_q      <= '0;
      rd_vld_q         <= 1'b0;
      out_vld_q        <= 1'b0;
      related_reason_q <= RELATED_REASON_RST;
      accept_verdict_q <= ACCEPT_VERDICT_RST;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        scan_addr_q <= '0;
        rd_vld_q    <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_vld_q <= issue;
        if (issue) begin
          scan_addr_q <= scan_addr_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RELATED_REASON: related_reason_q <= $signed(cfg_wdata_i);
          CFG_ACCEPT_VERDICT: accept_verdict_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  `FLHT_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (count_q == '0), "table not empty after reset")
  `FLHT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNTW'(TABLE_DEPTH), "row count past depth")
  `FLHT_ASSERT(a_finish_slot, clk_i, rst_ni, cmd_i.finish |-> (!out_vld_q || out_ready_i), "result overwrites pending result")

endmodule

// ===== rtl/flow_log_hit_counter_table_unit.sv =====
// top level of the flow log hit counter table
//
// channel   dir  transaction
// in_i      in   one operation: log, established, clear or read row
// out_o     out  one result per operation: status, row fields, entries used
// cfg       in   register write, no handshake
//
// log and established scan the row memory one row per cycle through its single read port
// a scan stops at the first matching row, or on a miss after the last used row
// one operation is in work at a time
// the result register lets a new operation start while the previous result waits
// out_o stalls hold the finishing operation until the result register frees
// reset empties the table at once, with no sweep over the memory
module flow_log_hit_counter_table_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  flht_stream_if.sink                      in_i,
  flht_stream_if.source                    out_o,
  input  logic                             cfg_we_i,
  input  logic [flht_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [flht_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import flht_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  logic      in_ready;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  assign in_item     = in_i.payload;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.payload = out_item;

  flht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_item.operation),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  flht_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .out_ready_i (out_o.ready)
  );

endmodule
